/* sv/plc_pkg.sv */
package plc_pkg;

    localparam int RADIUS_W  = 31;
    localparam int SLIM_W    = 21;
    localparam int HLIM_W    = 31;
    localparam int SCORE_W   = 20;
    localparam int ROOT_W    = 31;
    localparam int SQ_W      = 2 * ROOT_W;
    localparam int ID_W      = 16;
    localparam int POS_W     = 32;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_SLIMIT  = 2'd1;
    localparam logic [1:0] REG_HLIMIT  = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 31'd65536;
    localparam logic [SLIM_W-1:0]   SLIMIT_RST = 21'd65536;
    localparam logic [HLIM_W-1:0]   HLIMIT_RST = 31'd13107;
    localparam logic [SCORE_W-1:0]  SCORE_MAX  = 20'hFFFFF;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [SLIM_W-1:0]   score_limit;
        logic [HLIM_W-1:0]   heading_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] h;
        logic [ID_W-1:0]         id;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RSQ,
        S_CHECK,
        S_READ,
        S_DATA,
        S_TEST,
        S_SQX,
        S_SQY,
        S_SUM,
        S_CMP,
        S_ROOT,
        S_SCORE,
        S_FLUSH,
        S_WRITE
    } t_state;

endpackage

/* sv/plc_if.sv */
interface plc_pose_if;
    logic                                valid;
    logic                                ready;
    logic                                restart;
    logic [plc_pkg::ID_W-1:0]            pose_id;
    logic signed [plc_pkg::POS_W-1:0]    pos_x;
    logic signed [plc_pkg::POS_W-1:0]    pos_y;
    logic signed [plc_pkg::POS_W-1:0]    heading;

    modport source (output valid, restart, pose_id, pos_x, pos_y, heading, input ready);
    modport sink   (input valid, restart, pose_id, pos_x, pos_y, heading, output ready);
endinterface

interface plc_pair_if;
    logic                                valid;
    logic                                ready;
    logic [plc_pkg::ID_W-1:0]            earlier_id;
    logic [plc_pkg::ID_W-1:0]            later_id;
    logic [plc_pkg::SCORE_W-1:0]         pair_score;
    logic                                last_match;

    modport source (output valid, earlier_id, later_id, pair_score, last_match, input ready);
    modport sink   (input valid, earlier_id, later_id, pair_score, last_match, output ready);
endinterface

/* sv/plc_cfg.sv */
module plc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [plc_pkg::PADDR_W-1:0]  paddr,
    input  logic [plc_pkg::PDATA_W-1:0]  pwdata,
    output logic [plc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output plc_pkg::t_cfg                o_cfg
);

    plc_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius        <= plc_pkg::RADIUS_RST;
            r_cfg.score_limit   <= plc_pkg::SLIMIT_RST;
            r_cfg.heading_limit <= plc_pkg::HLIMIT_RST;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                plc_pkg::REG_RADIUS: r_cfg.radius        <= pwdata[plc_pkg::RADIUS_W-1:0];
                plc_pkg::REG_SLIMIT: r_cfg.score_limit   <= pwdata[plc_pkg::SLIM_W-1:0];
                plc_pkg::REG_HLIMIT: r_cfg.heading_limit <= pwdata[plc_pkg::HLIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            plc_pkg::REG_RADIUS: prdata = {1'b0, r_cfg.radius};
            plc_pkg::REG_SLIMIT: prdata = {11'b0, r_cfg.score_limit};
            plc_pkg::REG_HLIMIT: prdata = {1'b0, r_cfg.heading_limit};
            default:             prdata = '0;
        endcase
    end

endmodule

/* sv/plc_store.sv */
module plc_store #(
    parameter int WINDOW = 64,
    parameter int AW     = 6
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  plc_pkg::t_entry       i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output plc_pkg::t_entry       o_rdata
);

    plc_pkg::t_entry r_mem [WINDOW];
    plc_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/plc_isqrt.sv */
module plc_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [plc_pkg::SQ_W-1:0]      i_value,
    output logic                          o_done,
    output logic [plc_pkg::ROOT_W-1:0]    o_root
);

    localparam int REM_W = plc_pkg::ROOT_W + 3;
    localparam int CNT_W = $clog2(plc_pkg::ROOT_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(plc_pkg::ROOT_W - 1);

    logic                         r_busy;
    logic [CNT_W-1:0]             r_cnt;
    logic [plc_pkg::SQ_W-1:0]     r_val;
    logic [REM_W-1:0]             r_rem;
    logic [plc_pkg::ROOT_W-1:0]   r_root;
    logic                         r_done;
    logic [REM_W-1:0]             w_rem_sh;
    logic [REM_W-1:0]             w_trial;
    logic                         w_fit;

    // one result bit per cycle, two radicand bits brought down each step
    assign w_rem_sh = {r_rem[REM_W-3:0], r_val[plc_pkg::SQ_W-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_fit    = w_rem_sh >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[plc_pkg::SQ_W-3:0], 2'b00};
            r_rem  <= w_fit ? w_rem_sh - w_trial : w_rem_sh;
            r_root <= {r_root[plc_pkg::ROOT_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* sv/pose_loop_closure_detector_core.sv */
// Channel   Dir  Payload                                         Handshake
// i_pose    in   restart, pose_id, pos_x, pos_y, heading         valid/ready
// o_pair    out  earlier_id, later_id, pair_score, last_match    valid/ready
// apb       in   psel/penable/pwrite/paddr/pwdata -> prdata      pready tied high
//
// One pose at a time. After setup squares the radius, each of the up to WINDOW-1
// stored poses is read and rejected on offset or heading, else squared and rejected
// on distance, else passed through the 31-step square root unit and scored; the new
// pose is then written into the window.
// Reset clears the window fill count and slot pointer; entries are never cleared.
// A closure pair is held one deep so the last one can be flagged; the scan waits
// while that word cannot move into a full output register.
module pose_loop_closure_detector_core #(
    parameter int WINDOW = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    plc_pose_if.sink                      i_pose,
    plc_pair_if.source                    o_pair,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [plc_pkg::PADDR_W-1:0]   paddr,
    input  logic [plc_pkg::PDATA_W-1:0]   pwdata,
    output logic [plc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int AW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);
    localparam logic [CW-1:0] FILL_FULL = CW'(WINDOW);
    localparam logic [CW-1:0] N_MAX     = CW'(WINDOW - 1);
    localparam logic [AW-1:0] SLOT_LAST = AW'(WINDOW - 1);
    localparam logic [CW:0]   WIN_EXT   = (CW + 1)'(WINDOW);
    localparam int DIFF_W = plc_pkg::POS_W + 1;
    localparam int MW     = plc_pkg::ROOT_W;

    plc_pkg::t_cfg    w_cfg;
    plc_pkg::t_state  r_state, n_state;
    plc_pkg::t_entry  w_rdata, w_wdata;

    logic [CW-1:0]    r_fill, r_n, r_cnt;
    logic [AW-1:0]    r_slot, r_rd_slot;
    logic             r_pend_valid, r_out_valid;

    logic signed [plc_pkg::POS_W-1:0] r_x, r_y, r_h;
    logic [plc_pkg::ID_W-1:0]         r_id, r_sid, r_pend_eid;
    logic [DIFF_W-1:0]                r_ax, r_ay, r_ah;
    logic [plc_pkg::SQ_W-1:0]         r_r2, r_prod;
    logic [plc_pkg::SQ_W:0]           r_acc;
    logic [plc_pkg::SCORE_W-1:0]      r_pend_score;
    logic [plc_pkg::ID_W-1:0]         r_out_eid, r_out_lid;
    logic [plc_pkg::SCORE_W-1:0]      r_out_score;
    logic                             r_out_last;

    logic             w_accept, w_scan_done, w_test_fail, w_dist_fail, w_score_pass;
    logic             w_out_free;
    logic [CW-1:0]    w_fill_eff, w_n;
    logic [AW-1:0]    w_slot_eff, w_start;
    logic [CW:0]      w_start_ext;
    logic [MW-1:0]    w_mop;
    logic [plc_pkg::SQ_W-1:0] w_mul;
    logic signed [DIFF_W-1:0] w_dx, w_dy, w_dh;
    logic [plc_pkg::ROOT_W:0] w_score;
    logic [plc_pkg::SCORE_W-1:0] w_score_sat;
    logic             w_sqrt_done;
    logic [plc_pkg::ROOT_W-1:0] w_root;

    logic             s_mem_re, s_mem_we, s_sqrt_start, s_pend_load, s_out_load, s_out_last;

    plc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_wdata = '{x: r_x, y: r_y, h: r_h, id: r_id};

    plc_store #(.WINDOW(WINDOW), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (s_mem_we),
        .i_waddr (r_slot),
        .i_wdata (w_wdata),
        .i_re    (s_mem_re),
        .i_raddr (r_rd_slot),
        .o_rdata (w_rdata)
    );

    plc_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_sqrt_start),
        .i_value (r_acc[plc_pkg::SQ_W-1:0]),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    assign i_pose.ready = (r_state == plc_pkg::S_IDLE);
    assign w_accept     = i_pose.valid && (r_state == plc_pkg::S_IDLE);

    // window bounds after an optional restart
    assign w_fill_eff  = i_pose.restart ? '0 : r_fill;
    assign w_slot_eff  = i_pose.restart ? '0 : r_slot;
    assign w_n         = (w_fill_eff < N_MAX) ? w_fill_eff : N_MAX;
    assign w_start_ext = (CW + 1)'(w_slot_eff) + WIN_EXT - (CW + 1)'(w_n);
    assign w_start     = (w_start_ext >= WIN_EXT) ? AW'(w_start_ext - WIN_EXT)
                                                  : AW'(w_start_ext);

    // shared squaring unit
    always_comb begin
        unique case (r_state)
            plc_pkg::S_SQX: w_mop = r_ax[MW-1:0];
            plc_pkg::S_SQY: w_mop = r_ay[MW-1:0];
            default:        w_mop = w_cfg.radius;
        endcase
    end
    assign w_mul = {{MW{1'b0}}, w_mop} * {{MW{1'b0}}, w_mop};

    assign w_dx = DIFF_W'(r_x) - DIFF_W'(w_rdata.x);
    assign w_dy = DIFF_W'(r_y) - DIFF_W'(w_rdata.y);
    assign w_dh = DIFF_W'(r_h) - DIFF_W'(w_rdata.h);

    assign w_scan_done = (r_cnt == r_n);
    assign w_test_fail = (r_ax > DIFF_W'(w_cfg.radius)) || (r_ay > DIFF_W'(w_cfg.radius))
                      || (r_ah >= DIFF_W'(w_cfg.heading_limit));
    assign w_dist_fail = r_acc > {1'b0, r_r2};
    // heading already below its limit here, so it fits ROOT_W bits
    assign w_score      = {1'b0, w_root} + {1'b0, r_ah[plc_pkg::ROOT_W-1:0]};
    assign w_score_pass = w_score < (plc_pkg::ROOT_W + 1)'(w_cfg.score_limit);
    assign w_score_sat  = (w_score > (plc_pkg::ROOT_W + 1)'(plc_pkg::SCORE_MAX))
                          ? plc_pkg::SCORE_MAX : w_score[plc_pkg::SCORE_W-1:0];
    assign w_out_free   = !r_out_valid || o_pair.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plc_pkg::S_IDLE:  if (w_accept) n_state = plc_pkg::S_RSQ;
            plc_pkg::S_RSQ:   n_state = plc_pkg::S_CHECK;
            plc_pkg::S_CHECK: n_state = w_scan_done ? plc_pkg::S_FLUSH : plc_pkg::S_READ;
            plc_pkg::S_READ:  n_state = plc_pkg::S_DATA;
            plc_pkg::S_DATA:  n_state = plc_pkg::S_TEST;
            plc_pkg::S_TEST:  n_state = w_test_fail ? plc_pkg::S_CHECK : plc_pkg::S_SQX;
            plc_pkg::S_SQX:   n_state = plc_pkg::S_SQY;
            plc_pkg::S_SQY:   n_state = plc_pkg::S_SUM;
            plc_pkg::S_SUM:   n_state = plc_pkg::S_CMP;
            plc_pkg::S_CMP:   n_state = w_dist_fail ? plc_pkg::S_CHECK : plc_pkg::S_ROOT;
            plc_pkg::S_ROOT:  if (w_sqrt_done) n_state = plc_pkg::S_SCORE;
            plc_pkg::S_SCORE: begin
                if (!w_score_pass || !r_pend_valid || w_out_free) n_state = plc_pkg::S_CHECK;
            end
            plc_pkg::S_FLUSH: if (!r_pend_valid || w_out_free) n_state = plc_pkg::S_WRITE;
            plc_pkg::S_WRITE: n_state = plc_pkg::S_IDLE;
            default:          n_state = plc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_mem_re     = 1'b0;
        s_mem_we     = 1'b0;
        s_sqrt_start = 1'b0;
        s_pend_load  = 1'b0;
        s_out_load   = 1'b0;
        s_out_last   = 1'b0;
        unique case (r_state)
            plc_pkg::S_READ:  s_mem_re = 1'b1;
            plc_pkg::S_CMP:   s_sqrt_start = !w_dist_fail;
            plc_pkg::S_SCORE: begin
                s_pend_load = w_score_pass && (!r_pend_valid || w_out_free);
                s_out_load  = w_score_pass && r_pend_valid && w_out_free;
            end
            plc_pkg::S_FLUSH: begin
                s_out_load = r_pend_valid && w_out_free;
                s_out_last = 1'b1;
            end
            plc_pkg::S_WRITE: s_mem_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= plc_pkg::S_IDLE;
            r_fill       <= '0;
            r_slot       <= '0;
            r_n          <= '0;
            r_cnt        <= '0;
            r_rd_slot    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_fill    <= w_fill_eff;
                r_slot    <= w_slot_eff;
                r_n       <= w_n;
                r_cnt     <= '0;
                r_rd_slot <= w_start;
            end
            if (s_mem_re) begin
                r_cnt     <= r_cnt + 1'b1;
                r_rd_slot <= (r_rd_slot == SLOT_LAST) ? '0 : r_rd_slot + 1'b1;
            end
            if (s_mem_we) begin
                r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
                if (r_fill != FILL_FULL) r_fill <= r_fill + 1'b1;
            end
            if (s_pend_load) begin
                r_pend_valid <= 1'b1;
            end else if (s_out_load) begin
                r_pend_valid <= 1'b0;
            end
            if (s_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_pair.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x  <= i_pose.pos_x;
            r_y  <= i_pose.pos_y;
            r_h  <= i_pose.heading;
            r_id <= i_pose.pose_id;
        end
        if (r_state == plc_pkg::S_RSQ) r_r2 <= w_mul;
        if (r_state == plc_pkg::S_DATA) begin
            r_ax  <= w_dx[DIFF_W-1] ? DIFF_W'(-w_dx) : DIFF_W'(w_dx);
            r_ay  <= w_dy[DIFF_W-1] ? DIFF_W'(-w_dy) : DIFF_W'(w_dy);
            r_ah  <= w_dh[DIFF_W-1] ? DIFF_W'(-w_dh) : DIFF_W'(w_dh);
            r_sid <= w_rdata.id;
        end
        if (r_state == plc_pkg::S_SQX) r_acc  <= {1'b0, w_mul};
        if (r_state == plc_pkg::S_SQY) r_prod <= w_mul;
        if (r_state == plc_pkg::S_SUM) r_acc  <= r_acc + {1'b0, r_prod};
        if (s_out_load) begin
            r_out_eid   <= r_pend_eid;
            r_out_lid   <= r_id;
            r_out_score <= r_pend_score;
            r_out_last  <= s_out_last;
        end
        if (s_pend_load) begin
            r_pend_eid   <= r_sid;
            r_pend_score <= w_score_sat;
        end
    end

    assign o_pair.valid      = r_out_valid;
    assign o_pair.earlier_id = r_out_eid;
    assign o_pair.later_id   = r_out_lid;
    assign o_pair.pair_score = r_out_score;
    assign o_pair.last_match = r_out_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("window fill count beyond depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= r_n) && (r_n <= N_MAX))
        else $error("scan index beyond compared range");

    a_root_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_done |-> r_state == plc_pkg::S_ROOT)
        else $error("square root finished outside wait state");

    a_write_clears_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plc_pkg::S_WRITE) |-> !r_pend_valid)
        else $error("pending pair left when window written");

endmodule
